### hw/rtl/ssd_pkg.sv
// Shared types and constants for the setpoint settle detector.
// Used by ssd_front, ssd_back and setpoint_settle_detector; depends on nothing.
`default_nettype none

package ssd_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int CFG_W       = 24;
  localparam int WLEN_W      = 7;
  localparam int DIFF_W      = 25;
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 80;

  // Item class decided by the front end.
  typedef enum logic [1:0] {
    K_START = 2'd0,
    K_OK    = 2'd1,
    K_RANGE = 2'd2,
    K_FAULT = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] setpoint;
    logic [CFG_W-1:0]        error_tol;
    logic [CFG_W-1:0]        change_tol;
    logic [CFG_W-1:0]        dwell_samples;
    logic [CFG_W-1:0]        timeout_samples;
    logic [WLEN_W-1:0]       window_len;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/ssd_front.sv
// Input side of the settle detector: accepts words, classifies them and
// holds them in a two-entry queue for the back end. Depends on ssd_pkg.
`default_nettype none

module ssd_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [ssd_pkg::IN_TDATA_W-1:0]   in_tdata,   // sample, sample_status
  input  wire logic                             in_tuser,   // func
  output logic                                  q_valid,
  output ssd_pkg::item_t                        q_item,
  input  wire logic                             q_ready
);

  localparam logic       FUNC_START = 1'b0;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;

  ssd_pkg::item_t  queue_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r;
  ssd_pkg::item_t  new_item;
  logic [1:0]      status;
  logic            push, pop;

  always_comb begin
    status        = in_tdata[ssd_pkg::SAMPLE_W +: 2];
    new_item.sample = $signed(in_tdata[ssd_pkg::SAMPLE_W-1:0]);
    if (in_tuser == FUNC_START) begin
      new_item.kind = ssd_pkg::K_START;
    end else begin
      case (status)
        ST_OK:    new_item.kind = ssd_pkg::K_OK;
        ST_RANGE: new_item.kind = ssd_pkg::K_RANGE;
        default:  new_item.kind = ssd_pkg::K_FAULT;
      endcase
    end
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = queue_r[rd_ptr_r];
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ssd_back.sv
// Execution side of the settle detector: sample window memory, dwell and
// timeout counters, phase and the output register. Depends on ssd_pkg.
`default_nettype none

module ssd_back #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ssd_pkg::cfg_t                     cfg,
  input  wire logic                              q_valid,
  input  wire ssd_pkg::item_t                    q_item,
  output logic                                   q_ready,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [ssd_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = ssd_pkg::SAMPLE_W;
  localparam int DW = ssd_pkg::DIFF_W;
  localparam int KW = ssd_pkg::CFG_W;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RUN     = 2'd1,
    PH_SETTLED = 2'd2,
    PH_ABORT   = 2'd3
  } phase_t;

  logic signed [SW-1:0] mem [WINDOW_DEPTH];

  logic                 x_valid_r;
  ssd_pkg::item_t       x_item_r;
  logic signed [SW-1:0] rd_r, fwd_data_r, sp_fill_r;
  logic                 len1_r, fill_r, fwd_r;
  logic [AW-1:0]        wp_r, wp_nxt, raddr;
  logic [CW-1:0]        cnt_r, cnt_nxt, span;
  logic [AW:0]          rdiff;
  logic                 fill_nxt, fwd_nxt;
  phase_t               phase_r, phase_nxt;
  logic [KW-1:0]        dwell_r, dwell_nxt, tmo_r, tmo_nxt, dw, tm;
  logic                 out_valid_r, out_alarm_r, alarm;
  phase_t               out_phase_r;
  logic signed [DW-1:0] out_dev_r, out_chg_r, dev, chg, dev_o, chg_o;
  logic [KW-1:0]        out_dwell_r;
  logic [DW-1:0]        dev_mag, chg_mag;
  logic                 dev_oot, chg_oot;
  logic signed [SW-1:0] old_smp;
  logic                 x_fire, x_load, is_start, run, shift, restart;

  assign x_fire   = x_valid_r && (!out_valid_r || out_tready);
  assign x_load   = !x_valid_r || x_fire;
  assign q_ready  = x_load;
  assign is_start = (x_item_r.kind == ssd_pkg::K_START);
  assign run      = x_valid_r && !is_start && (phase_r == PH_RUN);
  assign shift    = x_fire && run;
  assign restart  = x_fire && is_start;

  // Effective window span and the address of the oldest sample that the
  // next item compares against.
  always_comb begin
    if (cfg.window_len == '0) begin
      span = CW'(2);
    end else if (32'(cfg.window_len) > 32'(WINDOW_DEPTH)) begin
      span = CW'(WINDOW_DEPTH);
    end else begin
      span = CW'(cfg.window_len);
    end

    if (!shift) begin
      wp_nxt = wp_r;
    end else if (wp_r == AW'(WINDOW_DEPTH - 1)) begin
      wp_nxt = '0;
    end else begin
      wp_nxt = wp_r + AW'(1);
    end

    if (restart) begin
      cnt_nxt = '0;
    end else if (shift && (cnt_r != CW'(WINDOW_DEPTH))) begin
      cnt_nxt = cnt_r + CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end

    rdiff = {1'b0, wp_nxt} - (AW+1)'(span - CW'(1));
    if (rdiff[AW]) begin
      raddr = AW'(rdiff + (AW+1)'(WINDOW_DEPTH));
    end else begin
      raddr = rdiff[AW-1:0];
    end

    fill_nxt = (span >= CW'(2)) && ((span - CW'(2)) >= cnt_nxt);
    fwd_nxt  = shift && (raddr == wp_r);
  end

  // Execution of the item held in the stage.
  always_comb begin
    if (len1_r) begin
      old_smp = x_item_r.sample;
    end else if (fwd_r) begin
      old_smp = fwd_data_r;
    end else if (fill_r) begin
      old_smp = sp_fill_r;
    end else begin
      old_smp = rd_r;
    end

    dev     = DW'(x_item_r.sample) - DW'(cfg.setpoint);
    chg     = DW'(x_item_r.sample) - DW'(old_smp);
    dev_mag = dev[DW-1] ? DW'(-dev) : DW'(dev);
    chg_mag = chg[DW-1] ? DW'(-chg) : DW'(chg);
    dev_oot = dev_mag > {1'b0, cfg.error_tol};
    chg_oot = chg_mag > {1'b0, cfg.change_tol};

    alarm     = 1'b0;
    dev_o     = '0;
    chg_o     = '0;
    dw        = dwell_r;
    tm        = tmo_r;
    phase_nxt = phase_r;
    dwell_nxt = dwell_r;
    tmo_nxt   = tmo_r;

    if (is_start) begin
      dwell_nxt = cfg.dwell_samples;
      tmo_nxt   = cfg.timeout_samples;
      phase_nxt = (cfg.dwell_samples == '0) ? PH_SETTLED : PH_RUN;
    end else if (phase_r == PH_RUN) begin
      if ((cfg.timeout_samples != '0) && (tmo_r == '0)) begin
        alarm = 1'b1;
        dw    = cfg.dwell_samples;
        tm    = cfg.timeout_samples;
      end
      case (x_item_r.kind)
        ssd_pkg::K_RANGE: begin
          dw = cfg.dwell_samples;
        end
        ssd_pkg::K_OK: begin
          dev_o = dev;
          chg_o = chg;
          if (dev_oot || chg_oot) begin
            dw = cfg.dwell_samples;
          end
        end
        default: begin
        end
      endcase
      if (x_item_r.kind == ssd_pkg::K_FAULT) begin
        phase_nxt = PH_ABORT;
        dwell_nxt = dw;
        tmo_nxt   = tm;
      end else begin
        dwell_nxt = (dw != '0) ? dw - KW'(1) : dw;
        tmo_nxt   = (tm != '0) ? tm - KW'(1) : tm;
        if (dwell_nxt == '0) begin
          phase_nxt = PH_SETTLED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      dwell_r     <= '0;
      tmo_r       <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      sp_fill_r   <= '0;
    end else begin
      if (x_load) begin
        x_valid_r <= q_valid;
      end
      if (x_fire) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        dwell_r     <= dwell_nxt;
        tmo_r       <= tmo_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (restart) begin
        sp_fill_r <= cfg.setpoint;
      end
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      mem[wp_r] <= x_item_r.sample;
    end
    if (x_load) begin
      x_item_r   <= q_item;
      rd_r       <= mem[raddr];
      len1_r     <= (span == CW'(1));
      fill_r     <= fill_nxt;
      fwd_r      <= fwd_nxt;
      fwd_data_r <= x_item_r.sample;
    end
    if (x_fire) begin
      out_phase_r <= phase_nxt;
      out_alarm_r <= alarm;
      out_dev_r   <= dev_o;
      out_chg_r   <= chg_o;
      out_dwell_r <= dwell_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_dwell_r, out_chg_r, out_dev_r, out_alarm_r, out_phase_r};

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(WINDOW_DEPTH))
    else $error("window fill count above depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= AW'(WINDOW_DEPTH - 1))
    else $error("window write pointer out of range");

  a_settled_dwell: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SETTLED |-> dwell_r == '0)
    else $error("settled with dwell remaining");

  a_run_dwell: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RUN |-> dwell_r != '0)
    else $error("running with dwell exhausted");

  a_alarm_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_alarm_r |-> out_phase_r != PH_IDLE)
    else $error("timeout alarm reported while idle");
`endif

endmodule

`default_nettype wire

### hw/rtl/setpoint_settle_detector.sv
// Top level of the setpoint settle detector: configuration registers, the
// front queue and the back end. Depends on ssd_pkg, ssd_front and ssd_back.
//
//   Port group | Dir | Handshake              | Payload
//   in_*       | in  | in_tvalid / in_tready  | tdata: sample, sample_status; tuser: func
//   out_*      | out | out_tvalid / out_tready| tdata: phase, alarm, deviation, change, dwell
//   cfg_*      | in  | cfg_we                 | cfg_addr index, cfg_wdata value
//
// One word per cycle sustained while the output is not stalled; a word passes the
// queue, the execute stage and the output register before its result appears.
// The sample window is a circular memory with a fill count, so a start word
// needs no clearing pass. A stalled output holds the execute stage; the two-entry
// queue then fills and drops in_tready.
`default_nettype none

module setpoint_settle_detector #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ssd_pkg::IN_TDATA_W-1:0]     in_tdata,   // sample[23:0], sample_status[25:24]
  input  wire logic                               in_tuser,   // func
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // phase[1:0], timeout_alarm[2], deviation[27:3], window_change[52:28],
  // dwell_remaining[76:53]
  output logic [ssd_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [ssd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [ssd_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam logic [ssd_pkg::CFG_ADDR_W-1:0] R_SETPOINT   = 3'd0;
  localparam logic [ssd_pkg::CFG_ADDR_W-1:0] R_ERROR_TOL  = 3'd1;
  localparam logic [ssd_pkg::CFG_ADDR_W-1:0] R_CHANGE_TOL = 3'd2;
  localparam logic [ssd_pkg::CFG_ADDR_W-1:0] R_DWELL      = 3'd3;
  localparam logic [ssd_pkg::CFG_ADDR_W-1:0] R_TIMEOUT    = 3'd4;
  localparam logic [ssd_pkg::CFG_ADDR_W-1:0] R_WINDOW_LEN = 3'd5;

  ssd_pkg::cfg_t   cfg_r;
  logic            q_valid, q_ready;
  ssd_pkg::item_t  q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint        <= '0;
      cfg_r.error_tol       <= '0;
      cfg_r.change_tol      <= '0;
      cfg_r.dwell_samples   <= '0;
      cfg_r.timeout_samples <= '0;
      cfg_r.window_len      <= ssd_pkg::WLEN_W'(2);
    end else if (cfg_we) begin
      case (cfg_addr)
        R_SETPOINT:   cfg_r.setpoint        <= $signed(cfg_wdata);
        R_ERROR_TOL:  cfg_r.error_tol       <= cfg_wdata;
        R_CHANGE_TOL: cfg_r.change_tol      <= cfg_wdata;
        R_DWELL:      cfg_r.dwell_samples   <= cfg_wdata;
        R_TIMEOUT:    cfg_r.timeout_samples <= cfg_wdata;
        R_WINDOW_LEN: cfg_r.window_len      <= cfg_wdata[ssd_pkg::WLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready)
  );

  ssd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### tb/settle_checker.sv
// Checker for the setpoint settle detector: follows register writes and accepted input words,
// predicts every report word and compares it field by field with the block's output.
// Depends on ssd_pkg for port widths and defines settle_tb_pkg, shared with the testbench top.

package settle_tb_pkg;

  localparam int WIN_DEPTH = 64;

  typedef enum logic [2:0] {
    REG_SETPOINT   = 3'd0,
    REG_ERROR_TOL  = 3'd1,
    REG_CHANGE_TOL = 3'd2,
    REG_DWELL      = 3'd3,
    REG_TIMEOUT    = 3'd4,
    REG_WINDOW_LEN = 3'd5
  } reg_idx_t;

  typedef enum logic {
    FUNC_START  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FAULT = 2'd2,
    ST_UNDEF = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RUN     = 2'd1,
    PH_SETTLED = 2'd2,
    PH_ABORTED = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic               alarm;
    logic signed [24:0] deviation;
    logic signed [24:0] change;
    logic [23:0]        dwell;
  } report_t;

endpackage

module settle_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [ssd_pkg::IN_TDATA_W-1:0]  in_tdata,   // sample[23:0], sample_status[25:24]
  input  wire logic                           in_tuser,   // func
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  // phase[1:0], timeout_alarm[2], deviation[27:3], window_change[52:28],
  // dwell_remaining[76:53]
  input  wire logic [ssd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [ssd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [ssd_pkg::CFG_W-1:0]       cfg_wdata,
  output int                                  fail_count,
  output int                                  pending_words,
  output int                                  settles_seen,
  output int                                  aborts_seen,
  output int                                  alarms_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import settle_tb_pkg::*;

  logic signed [23:0] sp_reg;
  logic [23:0]        etol_reg;
  logic [23:0]        ctol_reg;
  logic [23:0]        dwell_reg;
  logic [23:0]        tmo_reg;
  logic [6:0]         wlen_reg;

  logic signed [23:0] window [WIN_DEPTH];
  logic [23:0]        dwell_cnt;
  logic [23:0]        tmo_cnt;
  phase_t             run_ph;

  report_t            expected_reports [$];

  function automatic bit out_of_band(input logic signed [24:0] d, input logic [23:0] tol);
    int dv;
    int tv;
    dv = d;
    tv = int'(tol);
    return (dv > tv) || (dv < -tv);
  endfunction

  task automatic advance_settle(input func_t f, input logic signed [23:0] smp,
                                input status_t st);
    report_t r;
    phase_t  was;
    int      span;
    r = '0;
    was = run_ph;
    if (f == FUNC_START) begin
      for (int k = 0; k < WIN_DEPTH; k++) window[k] = sp_reg;
      dwell_cnt = dwell_reg;
      tmo_cnt = tmo_reg;
      run_ph = (dwell_cnt == 0) ? PH_SETTLED : PH_RUN;
      was = PH_IDLE;
    end else if (run_ph == PH_RUN) begin
      if (tmo_reg != 0 && tmo_cnt == 0) begin
        r.alarm = 1'b1;
        dwell_cnt = dwell_reg;
        tmo_cnt = tmo_reg;
      end
      for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = smp;
      if (st == ST_RANGE) begin
        dwell_cnt = dwell_reg;
      end else if (st != ST_OK) begin
        run_ph = PH_ABORTED;
      end else begin
        span = (wlen_reg == 0) ? 2 : (wlen_reg > WIN_DEPTH) ? WIN_DEPTH : int'(wlen_reg);
        r.deviation = {smp[23], smp} - {sp_reg[23], sp_reg};
        r.change = {smp[23], smp} - {window[span-1][23], window[span-1]};
        if (out_of_band(r.deviation, etol_reg) || out_of_band(r.change, ctol_reg))
          dwell_cnt = dwell_reg;
      end
      if (run_ph != PH_ABORTED) begin
        if (dwell_cnt != 0) dwell_cnt--;
        if (tmo_cnt != 0) tmo_cnt--;
        if (dwell_cnt == 0) run_ph = PH_SETTLED;
      end
    end
    r.phase = run_ph;
    r.dwell = dwell_cnt;
    if (r.alarm) alarms_seen++;
    if (was != run_ph && run_ph == PH_SETTLED) settles_seen++;
    if (was != run_ph && run_ph == PH_ABORTED) aborts_seen++;
    expected_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [24:0] want, input logic [24:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
    end
  endtask

  task automatic compare_report(input logic [ssd_pkg::OUT_TDATA_W-1:0] word);
    report_t want;
    if (expected_reports.size() == 0) begin
      fail_count++;
      $error("report word arrived with no prediction waiting");
    end else begin
      want = expected_reports.pop_front();
      check_field("phase", 25'(want.phase), 25'(word[1:0]));
      check_field("timeout_alarm", 25'(want.alarm), 25'(word[2]));
      check_field("deviation", want.deviation, word[27:3]);
      check_field("window_change", want.change, word[52:28]);
      check_field("dwell_remaining", 25'(want.dwell), 25'(word[76:53]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sp_reg = '0;
      etol_reg = '0;
      ctol_reg = '0;
      dwell_reg = '0;
      tmo_reg = '0;
      wlen_reg = 7'd2;
      for (int k = 0; k < WIN_DEPTH; k++) window[k] = '0;
      dwell_cnt = '0;
      tmo_cnt = '0;
      run_ph = PH_IDLE;
      expected_reports.delete();
      fail_count = 0;
      pending_words = 0;
      settles_seen = 0;
      aborts_seen = 0;
      alarms_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SETPOINT:   sp_reg = cfg_wdata;
          REG_ERROR_TOL:  etol_reg = cfg_wdata;
          REG_CHANGE_TOL: ctol_reg = cfg_wdata;
          REG_DWELL:      dwell_reg = cfg_wdata;
          REG_TIMEOUT:    tmo_reg = cfg_wdata;
          REG_WINDOW_LEN: wlen_reg = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        advance_settle(func_t'(in_tuser), in_tdata[23:0], status_t'(in_tdata[25:24]));
      if (out_tvalid && out_tready) compare_report(out_tdata);
      pending_words = expected_reports.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the settle detector testbench: clock, reset, register writes and paced stimulus.
// Depends on ssd_pkg, setpoint_settle_detector and settle_checker (with settle_tb_pkg).

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import settle_tb_pkg::*;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ssd_pkg::IN_TDATA_W-1:0]  in_tdata;   // sample[23:0], sample_status[25:24]
  logic                           in_tuser;   // func
  logic                           out_tvalid;
  logic                           out_tready;
  // phase[1:0], timeout_alarm[2], deviation[27:3], window_change[52:28],
  // dwell_remaining[76:53]
  logic [ssd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                           cfg_we;
  logic [ssd_pkg::CFG_ADDR_W-1:0]  cfg_addr;
  logic [ssd_pkg::CFG_W-1:0]       cfg_wdata;

  int fail_count;
  int pending_words;
  int settles_seen;
  int aborts_seen;
  int alarms_seen;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent = 0;
  int settings_used = 0;
  int cur_sp;
  int cur_jitter;
  int cur_dwell;

  always #5ns clk = ~clk;

  setpoint_settle_detector uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_addr, .cfg_wdata
  );

  settle_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_addr, .cfg_wdata,
    .fail_count, .pending_words, .settles_seen, .aborts_seen, .alarms_seen
  );

  function automatic int any_sample();
    logic [23:0] r;
    r = 24'($urandom);
    return int'($signed(r));
  endfunction

  function automatic int near_setpoint(input int spread);
    int v;
    v = cur_sp + int'($urandom_range(2 * spread)) - spread;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[23:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input int sp, input int etol, input int ctol, input int dwell,
                                input int tmo, input int wlen);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_ERROR_TOL, etol);
    write_reg(REG_CHANGE_TOL, ctol);
    write_reg(REG_DWELL, dwell);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_WINDOW_LEN, wlen);
    cur_sp = sp;
    cur_dwell = dwell;
    cur_jitter = etol;
    if (ctol / 2 < cur_jitter) cur_jitter = ctol / 2;
    if (cur_jitter > 1000) cur_jitter = 1000;
    settings_used++;
  endtask

  task automatic send_word(input func_t f, input int value, input status_t st);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata <= $urandom;
      in_tuser <= 1'($urandom_range(1));
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {6'd0, st, value[23:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_settings();
    int sp;
    int etol;
    int ctol;
    int dwell;
    int tmo;
    int wlen;
    case ($urandom_range(7))
      0: sp = -8388608;
      1: sp = 8388607;
      2: sp = 0;
      default: sp = any_sample();
    endcase
    case ($urandom_range(5))
      0: etol = 0;
      1: etol = 24'hFFFFFF;
      default: etol = $urandom_range(2000);
    endcase
    case ($urandom_range(5))
      0: ctol = 0;
      1: ctol = 24'hFFFFFF;
      default: ctol = $urandom_range(2000);
    endcase
    case ($urandom_range(9))
      0: dwell = 0;
      1: dwell = 24'hFFFFFF;
      default: dwell = $urandom_range(12, 1);
    endcase
    case ($urandom_range(5))
      0, 1: tmo = 0;
      2: tmo = 24'hFFFFFF;
      default: tmo = $urandom_range(20, 1);
    endcase
    case ($urandom_range(7))
      0: wlen = 0;
      1: wlen = 64;
      2: wlen = 127;
      3: wlen = $urandom_range(126, 65);
      default: wlen = $urandom_range(8, 1);
    endcase
    apply_settings(sp, etol, ctol, dwell, tmo, wlen);
  endtask

  task automatic run_cycle(input int n);
    int pick;
    send_word(FUNC_START, any_sample(), status_t'($urandom_range(3)));
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 80) send_word(FUNC_SAMPLE, near_setpoint(cur_jitter), ST_OK);
      else if (pick < 88) send_word(FUNC_SAMPLE, any_sample(), ST_OK);
      else if (pick < 95) send_word(FUNC_SAMPLE, near_setpoint(cur_jitter), ST_RANGE);
      else if (pick < 98) send_word(FUNC_SAMPLE, any_sample(), ST_FAULT);
      else send_word(FUNC_SAMPLE, any_sample(), ST_UNDEF);
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < recv_idle_pct) out_tready <= 1'b0;
      else out_tready <= 1'b1;
    end
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int send_pcts [3];
    int recv_pcts [3];
    int mode_start;
    send_pcts = '{28, 73, 0};
    recv_pcts = '{73, 28, 0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = send_pcts[0];
    recv_idle_pct = recv_pcts[0];

    apply_settings(0, 256, 256, 3, 0, 2);
    send_word(FUNC_SAMPLE, 5, ST_OK);
    send_word(FUNC_START, 0, ST_OK);
    send_word(FUNC_SAMPLE, 0, ST_OK);
    send_word(FUNC_SAMPLE, 100000, ST_OK);
    send_word(FUNC_SAMPLE, 0, ST_RANGE);
    send_word(FUNC_SAMPLE, 0, ST_OK);
    send_word(FUNC_SAMPLE, 10, ST_OK);
    send_word(FUNC_SAMPLE, -10, ST_OK);
    send_word(FUNC_SAMPLE, 7, ST_OK);
    send_word(FUNC_START, 0, ST_OK);
    send_word(FUNC_SAMPLE, 1, ST_FAULT);
    send_word(FUNC_SAMPLE, 0, ST_OK);
    send_word(FUNC_START, 0, ST_OK);
    send_word(FUNC_SAMPLE, 0, ST_UNDEF);
    wait_drained();

    // A zero dwell settles on the start word itself.
    apply_settings(-8388608, 0, 0, 0, 0, 0);
    send_word(FUNC_START, 0, ST_OK);
    send_word(FUNC_SAMPLE, 8388607, ST_OK);
    wait_drained();

    // Full-scale deviation with wide tolerances, so only the timeout restarts the count.
    apply_settings(-8388608, 24'hFFFFFF, 24'hFFFFFF, 5, 2, 127);
    send_word(FUNC_START, 0, ST_OK);
    repeat (4) send_word(FUNC_SAMPLE, 8388607, ST_OK);
    send_word(FUNC_SAMPLE, -8388608, ST_OK);
    wait_drained();

    apply_settings(8388607, 0, 0, 2, 0, 1);
    send_word(FUNC_START, 0, ST_OK);
    send_word(FUNC_SAMPLE, -8388608, ST_OK);
    send_word(FUNC_SAMPLE, 8388607, ST_OK);
    wait_drained();

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = send_pcts[m];
      recv_idle_pct = recv_pcts[m];
      mode_start = words_sent;
      while (words_sent - mode_start < 400) begin
        wait_drained();
        random_settings();
        repeat ($urandom_range(5, 2)) begin
          if ($urandom_range(9) == 0)
            send_word(FUNC_SAMPLE, any_sample(), status_t'($urandom_range(3)));
          run_cycle(((cur_dwell > 12) ? 12 : cur_dwell) + $urandom_range(8) + 1);
        end
      end
    end
    wait_drained();

    $display("Run covered %0d words over %0d register settings and three pacing modes.",
             words_sent, settings_used);
    $display("Predicted %0d settles, %0d aborts and %0d timeout alarms.",
             settles_seen, aborts_seen, alarms_seen);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_front.sv
hw/rtl/ssd_back.sv
hw/rtl/setpoint_settle_detector.sv
tb/settle_checker.sv
tb/testbench.sv
